FILE: design/mpe_pkg.sv
// mpe_pkg: shared types and constants for the Mandelbrot pixel escape core.
// Holds the controller state encoding, the controller/datapath command and
// status structs, register indexes and default parameter values. No dependencies.
package mpe_pkg;

   localparam int DATA_WIDTH       = 32;
   localparam int COORD_WIDTH      = 7;
   localparam int ADDR_WIDTH       = 4;
   localparam int DIV_STEPS        = 2;
   localparam int DIV_CNT_WIDTH    = 1;

   localparam int COLUMNS_DEFAULT   = 96;
   localparam int ROWS_DEFAULT      = 68;
   localparam int MAX_ITER_DEFAULT  = 150;
   localparam int FRAC_BITS_DEFAULT = 25;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_REAL_MIN = 2'd0;
   localparam logic [1:0] REG_REAL_MAX = 2'd1;
   localparam logic [1:0] REG_IMAG_MIN = 2'd2;
   localparam logic [1:0] REG_IMAG_MAX = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_FIX  = 7'b0000100,
      S_MAP  = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_UPD  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture pixel, window spans, start dividers
      logic div_step;  // one partial reciprocal product per divider
      logic fix;       // apply sign to the step quotients
      logic map;       // form c, clear z and the count
      logic mul;       // register the four products
      logic upd;       // escape test and z update
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic escape;    // |z|^2 has reached 4
      logic last;      // count has reached its limit
   } status_type;

endpackage

FILE: design/mandelbrot_pixel_escape_core.sv
// Mandelbrot pixel escape core: one pixel per start, one result strobe per pixel.
// After a start it runs two reciprocal steps, a sign fix and the mapping, then
// iterates product registers, then update, for N (1..MAX_ITER) escape tests.
// A new start is taken only while idle; busy stays high until the strobe.
// Synchronous reset idles the controller and loads the default -2..1, -2..2 window.
module mandelbrot_pixel_escape_core #(
   parameter int COLUMNS   = mpe_pkg::COLUMNS_DEFAULT,
   parameter int ROWS      = mpe_pkg::ROWS_DEFAULT,
   parameter int MAX_ITER  = mpe_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = mpe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic [mpe_pkg::COORD_WIDTH-1:0]    req_column,
   input  logic [mpe_pkg::COORD_WIDTH-1:0]    req_row,
   // result channel, one-cycle strobe, never stalled
   output logic                               rsp_valid,
   output logic [mpe_pkg::COORD_WIDTH-1:0]    rsp_out_column,
   output logic [mpe_pkg::COORD_WIDTH-1:0]    rsp_out_row,
   output logic                               rsp_pixel_on,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mpe_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [mpe_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [mpe_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                               pready
);

   localparam int DW = mpe_pkg::DATA_WIDTH;
   // window reset values in Q(31-FRAC_BITS).FRAC_BITS
   localparam logic signed [DW-1:0] REAL_MIN_RST = -(32'sd2 <<< FRAC_BITS);
   localparam logic signed [DW-1:0] REAL_MAX_RST =  (32'sd1 <<< FRAC_BITS);
   localparam logic signed [DW-1:0] IMAG_MIN_RST = -(32'sd2 <<< FRAC_BITS);
   localparam logic signed [DW-1:0] IMAG_MAX_RST =  (32'sd2 <<< FRAC_BITS);

   logic signed [DW-1:0] real_min_ff, real_min_in;
   logic signed [DW-1:0] real_max_ff, real_max_in;
   logic signed [DW-1:0] imag_min_ff, imag_min_in;
   logic signed [DW-1:0] imag_max_ff, imag_max_in;

   logic                 wr_en;
   logic [1:0]           reg_idx;
   mpe_pkg::cmd_type     cmd;
   mpe_pkg::status_type  status;

   // Register port: zero wait states, write in the access phase.
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      real_min_in = real_min_ff;
      real_max_in = real_max_ff;
      imag_min_in = imag_min_ff;
      imag_max_in = imag_max_ff;
      if (wr_en) begin
         case (reg_idx)
            mpe_pkg::REG_REAL_MIN: real_min_in = pwdata;
            mpe_pkg::REG_REAL_MAX: real_max_in = pwdata;
            mpe_pkg::REG_IMAG_MIN: imag_min_in = pwdata;
            mpe_pkg::REG_IMAG_MAX: imag_max_in = pwdata;
            default: begin
               real_min_in = real_min_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mpe_pkg::REG_REAL_MIN: prdata = real_min_ff;
         mpe_pkg::REG_REAL_MAX: prdata = real_max_ff;
         mpe_pkg::REG_IMAG_MIN: prdata = imag_min_ff;
         mpe_pkg::REG_IMAG_MAX: prdata = imag_max_ff;
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_min_ff <= REAL_MIN_RST;
         real_max_ff <= REAL_MAX_RST;
         imag_min_ff <= IMAG_MIN_RST;
         imag_max_ff <= IMAG_MAX_RST;
      end else begin
         real_min_ff <= real_min_in;
         real_max_ff <= real_max_in;
         imag_min_ff <= imag_min_in;
         imag_max_ff <= imag_max_in;
      end
   end

   // Controller: sequences divide, sign fix, map and the multiply/update iteration loop.
   mpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: holds the pixel, the point c, z and the products.
   mpe_dp #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .column     (req_column),
      .row        (req_row),
      .real_min   (real_min_ff),
      .real_max   (real_max_ff),
      .imag_min   (imag_min_ff),
      .imag_max   (imag_max_ff),
      .out_column (rsp_out_column),
      .out_row    (rsp_out_row),
      .pixel_on   (rsp_pixel_on)
   );

`ifndef NO_ASSERTIONS
   // an accepted start must hold the core busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("start transfer did not raise busy");

   // the result strobe lasts one cycle and frees the core straight after
   a_strobe_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe not followed by idle");

   // a result only while a pixel is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // controller drives at most one datapath command a cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.fix, cmd.map, cmd.mul, cmd.upd}))
      else $error("overlapping datapath commands");
`endif

endmodule

FILE: design/mpe_div.sv
// mpe_div: divides a 32-bit magnitude by a constant divisor through a rounded-up
// reciprocal, accumulated over two narrow multiply steps. Depends on mpe_pkg.
module mpe_div #(
   parameter int DIVISOR = mpe_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            load,
   input  logic                            step,
   input  logic [mpe_pkg::DATA_WIDTH-1:0]  dividend,
   output logic [mpe_pkg::DATA_WIDTH-1:0]  quotient
);

   localparam int DW   = mpe_pkg::DATA_WIDTH;
   localparam int LG   = $clog2(DIVISOR);
   localparam int SH   = DW + LG;
   localparam int LO_W = DW / 2;
   localparam int HI_W = DW + 1 - LO_W;
   localparam int PW   = 2 * DW + 1;
   localparam int RW   = 2 * DW;
   // ceil(2^SH / DIVISOR) gives the exact floor quotient for any 32-bit dividend
   localparam logic [RW-1:0] RECIP = ((RW'(1) << SH) + RW'(DIVISOR - 1)) / RW'(DIVISOR);
   localparam logic [LO_W-1:0] M_LO = RECIP[LO_W-1:0];
   localparam logic [HI_W-1:0] M_HI = RECIP[DW:LO_W];

   logic [DW-1:0]       num_ff, num_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic                hi_ff, hi_in;
   logic [HI_W-1:0]     mpart;
   logic [DW+HI_W-1:0]  prod;
   logic [PW-1:0]       addend;

   always_comb begin
      // low half of the reciprocal first, then the high half shifted up
      mpart  = hi_ff ? M_HI : HI_W'(M_LO);
      prod   = num_ff * mpart;
      addend = hi_ff ? {prod, {LO_W{1'b0}}} : PW'(prod);
      num_in = num_ff;
      acc_in = acc_ff;
      hi_in  = hi_ff;
      if (load) begin
         num_in = dividend;
         acc_in = '0;
         hi_in  = 1'b0;
      end else if (step) begin
         acc_in = acc_ff + addend;
         hi_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      acc_ff <= acc_in;
      hi_ff  <= hi_in;
   end

   assign quotient = DW'(acc_ff >> SH);

endmodule

FILE: design/mpe_ctrl.sv
// mpe_ctrl: sequencing state machine of the pixel escape core.
// Issues datapath commands, counts divider steps. Depends on mpe_pkg.
module mpe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mpe_pkg::status_type  status,
   output mpe_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   mpe_pkg::state_type                  state_ff, state_in;
   logic [mpe_pkg::DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         mpe_pkg::S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = mpe_pkg::S_DIV;
            end
         end
         mpe_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == mpe_pkg::DIV_CNT_WIDTH'(mpe_pkg::DIV_STEPS - 1)) begin
               state_in = mpe_pkg::S_FIX;
            end
         end
         mpe_pkg::S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = mpe_pkg::S_MAP;
         end
         mpe_pkg::S_MAP: begin
            cmd.map  = 1'b1;
            state_in = mpe_pkg::S_MUL;
         end
         mpe_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = mpe_pkg::S_UPD;
         end
         mpe_pkg::S_UPD: begin
            cmd.upd = 1'b1;
            if (status.escape || status.last) begin
               state_in = mpe_pkg::S_DONE;
            end else begin
               state_in = mpe_pkg::S_MUL;
            end
         end
         mpe_pkg::S_DONE: begin
            state_in = mpe_pkg::S_IDLE;
         end
         default: begin
            state_in = mpe_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpe_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = state_ff != mpe_pkg::S_IDLE;
   assign rsp_valid = state_ff == mpe_pkg::S_DONE;

endmodule

FILE: design/mpe_dp.sv
// mpe_dp: datapath of the pixel escape core - step dividers, coordinate
// mapping, product registers and the z update. Depends on mpe_pkg, mpe_div.
module mpe_dp #(
   parameter int COLUMNS   = mpe_pkg::COLUMNS_DEFAULT,
   parameter int ROWS      = mpe_pkg::ROWS_DEFAULT,
   parameter int MAX_ITER  = mpe_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = mpe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  mpe_pkg::cmd_type                       cmd,
   output mpe_pkg::status_type                    status,
   input  logic        [mpe_pkg::COORD_WIDTH-1:0] column,
   input  logic        [mpe_pkg::COORD_WIDTH-1:0] row,
   input  logic signed [mpe_pkg::DATA_WIDTH-1:0]  real_min,
   input  logic signed [mpe_pkg::DATA_WIDTH-1:0]  real_max,
   input  logic signed [mpe_pkg::DATA_WIDTH-1:0]  imag_min,
   input  logic signed [mpe_pkg::DATA_WIDTH-1:0]  imag_max,
   output logic        [mpe_pkg::COORD_WIDTH-1:0] out_column,
   output logic        [mpe_pkg::COORD_WIDTH-1:0] out_row,
   output logic                                   pixel_on
);

   localparam int DW = mpe_pkg::DATA_WIDTH;
   localparam int PW = 2 * mpe_pkg::DATA_WIDTH;
   localparam int CW = $clog2(MAX_ITER);
   localparam int CDW = mpe_pkg::COORD_WIDTH;
   localparam logic signed [PW-1:0] LIMIT = 64'sd4 <<< FRAC_BITS;

   logic [CDW-1:0]           col_ff, col_in, row_ff, row_in;
   logic                     rneg_ff, rneg_in, ineg_ff, ineg_in;
   logic signed [DW-1:0]     rstep_ff, rstep_in, istep_ff, istep_in;
   logic signed [DW-1:0]     p_ff, p_in, q_ff, q_in;
   logic signed [DW-1:0]     re_ff, re_in, im_ff, im_in;
   logic signed [PW-1:0]     rr_ff, rr_in, ii_ff, ii_in, sd_ff, sd_in, ri_ff, ri_in;
   logic [CW-1:0]            k_ff, k_in;
   logic                     pix_ff, pix_in;

   logic signed [DW-1:0]     rspan, ispan, sum_w, diff_w;
   logic [DW-1:0]            rmag, imag_mag, rquo, iquo;
   logic signed [PW-1:0]     mag_w, sd_sh, ri_sh;

   mpe_div #(.DIVISOR(ROWS)) u_rdiv (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.div_step),
      .dividend (rmag),
      .quotient (rquo)
   );

   mpe_div #(.DIVISOR(COLUMNS)) u_idiv (
      .clock    (clock),
      .load     (cmd.load),
      .step     (cmd.div_step),
      .dividend (imag_mag),
      .quotient (iquo)
   );

   always_comb begin
      rspan    = real_max - real_min;
      ispan    = imag_max - imag_min;
      rmag     = rspan[DW-1] ? DW'(-rspan) : DW'(rspan);
      imag_mag = ispan[DW-1] ? DW'(-ispan) : DW'(ispan);
      sum_w    = re_ff + im_ff;
      diff_w   = re_ff - im_ff;
      mag_w    = (rr_ff >>> FRAC_BITS) + (ii_ff >>> FRAC_BITS);
      sd_sh    = sd_ff >>> FRAC_BITS;
      ri_sh    = ri_ff >>> FRAC_BITS;
      status.escape = mag_w >= LIMIT;
      status.last   = k_ff == CW'(MAX_ITER - 1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      rneg_in  = rneg_ff;
      ineg_in  = ineg_ff;
      rstep_in = rstep_ff;
      istep_in = istep_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      sd_in    = sd_ff;
      ri_in    = ri_ff;
      k_in     = k_ff;
      pix_in   = pix_ff;
      if (cmd.load) begin
         col_in  = column;
         row_in  = row;
         rneg_in = rspan[DW-1];
         ineg_in = ispan[DW-1];
      end
      if (cmd.fix) begin
         // truncate toward zero: negate the magnitude quotient
         rstep_in = rneg_ff ? -$signed(rquo) : $signed(rquo);
         istep_in = ineg_ff ? -$signed(iquo) : $signed(iquo);
      end
      if (cmd.map) begin
         p_in  = real_min + DW'(rstep_ff * $signed({{(DW-CDW){1'b0}}, row_ff}));
         q_in  = imag_min + DW'(istep_ff * $signed({{(DW-CDW){1'b0}}, col_ff}));
         re_in = '0;
         im_in = '0;
         k_in  = '0;
      end
      if (cmd.mul) begin
         rr_in = re_ff * re_ff;
         ii_in = im_ff * im_ff;
         sd_in = sum_w * diff_w;
         ri_in = re_ff * im_ff;
      end
      if (cmd.upd) begin
         pix_in = status.escape && (k_ff >= CW'(2));
         if (!status.escape && !status.last) begin
            re_in = sd_sh[DW-1:0] + p_ff;
            im_in = {ri_sh[DW-2:0], 1'b0} + q_ff;
            k_in  = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      rneg_ff  <= rneg_in;
      ineg_ff  <= ineg_in;
      rstep_ff <= rstep_in;
      istep_ff <= istep_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      re_ff    <= re_in;
      im_ff    <= im_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      sd_ff    <= sd_in;
      ri_ff    <= ri_in;
      k_ff     <= k_in;
      pix_ff   <= pix_in;
   end

   assign out_column = col_ff;
   assign out_row    = row_ff;
   assign pixel_on   = pix_ff;

endmodule
